// ===== rtl/core/ll1p_pkg.sv =====
package ll1p_pkg;

   // request modes carried in req_tuser
   localparam logic [1:0] MODE_TOKEN  = 2'd0;
   localparam logic [1:0] MODE_CELL   = 2'd1;
   localparam logic [1:0] MODE_SYMBOL = 2'd2;
   localparam logic [1:0] MODE_LENGTH = 2'd3;

   // event kinds carried in rsp_tuser
   localparam logic [2:0] EV_MATCH    = 3'd0;
   localparam logic [2:0] EV_MISMATCH = 3'd1;
   localparam logic [2:0] EV_NO_ENTRY = 3'd2;
   localparam logic [2:0] EV_FINISH   = 3'd3;
   localparam logic [2:0] EV_OVERFLOW = 3'd4;

   // configuration register indexes
   localparam logic [1:0] CSR_NT_BASE = 2'd0;
   localparam logic [1:0] CSR_START   = 2'd1;
   localparam logic [1:0] CSR_SYNC    = 2'd2;
   localparam logic [1:0] CSR_EOF     = 2'd3;

   localparam logic [8:0] RST_NT_BASE = 9'd256;
   localparam logic [8:0] RST_START   = 9'd256;
   localparam logic [7:0] RST_SYNC    = 8'd59;
   localparam logic [7:0] RST_EOF     = 8'd0;

   // per-token limits on results and rule expansions
   localparam int          RESULT_W     = 7;
   localparam logic [6:0]  RESULT_LIMIT = 7'd63;
   localparam int          EXP_W        = 13;
   localparam logic [12:0] EXPAND_LIMIT = 13'd4096;

   // wide enough for the largest supported stack
   localparam int SP_STAT_W = 11;

   typedef struct packed {
      logic [8:0] nt_base;
      logic [8:0] start_sym;
      logic [7:0] sync_tok;
      logic [7:0] eof_tok;
   } cfg_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] token_code;
      logic [5:0] row;
      logic [7:0] col;
      logic [7:0] rule;
      logic       entry_valid;
      logic [2:0] slot;
      logic [8:0] symbol;
      logic [3:0] length;
      logic       store_ok;
   } item_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [8:0] symbol;
      logic [7:0] token;
      logic       last;
   } event_type;

   typedef struct packed {
      logic                 clear_busy;
      logic                 finished;
      logic [SP_STAT_W-1:0] stack_count;
   } status_type;

endpackage

// ===== rtl/core/ll1p_front.sv =====
module ll1p_front import ll1p_pkg::*; #(
   parameter int NUM_RULES        = 256,
   parameter int NUM_NONTERMINALS = 64,
   parameter int NUM_TOKENS       = 256,
   parameter int MAX_RULE_LEN     = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        clear_busy,
   output logic        q_valid,
   output item_type    q_item,
   input  logic        q_pop
);

   item_type   cls;
   item_type   fifo_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   // unpack and classify the request
   always_comb begin
      cls.mode        = req_tuser;
      cls.token_code  = req_tdata[7:0];
      cls.row         = req_tdata[13:8];
      cls.col         = req_tdata[21:14];
      cls.rule        = req_tdata[29:22];
      cls.entry_valid = req_tdata[30];
      cls.slot        = req_tdata[33:31];
      cls.symbol      = req_tdata[42:34];
      if (32'(req_tdata[46:43]) > MAX_RULE_LEN) begin
         cls.length = 4'(MAX_RULE_LEN);
      end else begin
         cls.length = req_tdata[46:43];
      end
      unique case (req_tuser)
         MODE_CELL: begin
            cls.store_ok = (32'(cls.row) < NUM_NONTERMINALS) && (32'(cls.col) < NUM_TOKENS);
         end
         MODE_SYMBOL: begin
            cls.store_ok = (32'(cls.rule) < NUM_RULES) && (32'(cls.slot) < MAX_RULE_LEN);
         end
         MODE_LENGTH: begin
            cls.store_ok = 32'(cls.rule) < NUM_RULES;
         end
         default: begin
            cls.store_ok = 1'b1;
         end
      endcase
   end

   assign req_tready = (count_ff != 2'd2) && !clear_busy;
   assign push       = req_tvalid && req_tready;
   assign q_valid    = count_ff != 2'd0;
   assign q_item     = fifo_ff[rd_ptr_ff];

   // advance queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // hold queued requests
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ===== rtl/core/ll1p_back.sv =====
module ll1p_back import ll1p_pkg::*; #(
   parameter int STACK_DEPTH      = 64,
   parameter int MAX_RULE_LEN     = 8,
   parameter int NUM_RULES        = 256,
   parameter int NUM_NONTERMINALS = 64,
   parameter int NUM_TOKENS       = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       q_valid,
   input  item_type   q_item,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output event_type  rsp_event,
   output status_type stat
);

   localparam int SP_W  = $clog2(STACK_DEPTH + 1);
   localparam int SA_W  = $clog2(STACK_DEPTH);
   localparam int CELLS = NUM_NONTERMINALS * NUM_TOKENS;
   localparam int CA_W  = $clog2(CELLS);
   localparam int RA_W  = $clog2(NUM_RULES);
   localparam int RSA_W = $clog2(NUM_RULES * MAX_RULE_LEN);

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_STEP     = 4'd2;
   localparam logic [3:0] S_CELL     = 4'd3;
   localparam logic [3:0] S_SCAN     = 4'd4;
   localparam logic [3:0] S_LEN      = 4'd5;
   localparam logic [3:0] S_EXP_RD   = 4'd6;
   localparam logic [3:0] S_EXP_WR   = 4'd7;
   localparam logic [3:0] S_FIN_EMIT = 4'd8;
   localparam logic [3:0] S_FINAL    = 4'd9;

   logic [3:0]          state_ff, state_in;
   logic [SP_W-1:0]     sp_ff, sp_in;
   logic [RESULT_W-1:0] n_ff, n_in;
   logic [EXP_W-1:0]    exp_ff, exp_in;
   logic [7:0]          tok_ff, tok_in;
   logic [RA_W-1:0]     rule_ff, rule_in;
   logic [3:0]          cnt_ff, cnt_in;
   logic                started_ff, started_in;
   logic                skip_ff, skip_in;
   logic                fin_ff, fin_in;
   logic [CA_W-1:0]     clr_ff, clr_in;
   logic                look_ok_ff, look_ok_in;
   logic                pend_valid_ff, pend_valid_in;
   event_type           pend_ff, pend_in;
   logic                out_valid_ff, out_valid_in;
   event_type           out_ff, out_in;

   // memories
   logic [8:0] stack_mem [STACK_DEPTH];
   logic [8:0] cell_mem  [CELLS];
   logic [8:0] sym_mem   [NUM_RULES * MAX_RULE_LEN];
   logic [3:0] len_mem   [NUM_RULES];

   logic [8:0]       top_ff;
   logic             stk_we;
   logic [SA_W-1:0]  stk_waddr, stk_raddr;
   logic [8:0]       stk_wdata;
   logic [8:0]       cell_rd_ff;
   logic             cell_we;
   logic [CA_W-1:0]  cell_waddr, cell_raddr;
   logic [8:0]       cell_wdata;
   logic [8:0]       sym_rd_ff;
   logic             sym_we;
   logic [RSA_W-1:0] sym_waddr, sym_raddr;
   logic [3:0]       len_rd_ff;
   logic             len_we;
   logic [RA_W-1:0]  len_addr;

   logic             out_free, can_emit, emit_go, out_load;
   logic [2:0]       emit_kind;
   logic [8:0]       emit_sym;
   logic [8:0]       row9;
   logic [SP_W:0]    need;
   logic [SP_W-1:0]  sp_dec;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign can_emit  = !pend_valid_ff || out_free;
   assign row9      = top_ff - cfg.nt_base;
   assign need      = (SP_W+1)'(sp_ff) - 1'b1 + (SP_W+1)'(len_rd_ff);
   assign sp_dec    = sp_ff - 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_event = out_ff;

   assign stat.clear_busy  = state_ff == S_CLEAR;
   assign stat.finished    = fin_ff;
   assign stat.stack_count = SP_STAT_W'(sp_ff);

   // sequence one request through the stack machine
   always_comb begin
      state_in   = state_ff;
      sp_in      = sp_ff;
      n_in       = n_ff;
      exp_in     = exp_ff;
      tok_in     = tok_ff;
      rule_in    = rule_ff;
      cnt_in     = cnt_ff;
      started_in = started_ff;
      skip_in    = skip_ff;
      fin_in     = fin_ff;
      clr_in     = clr_ff;
      look_ok_in = look_ok_ff;
      q_pop      = 1'b0;
      emit_go    = 1'b0;
      emit_kind  = EV_FINISH;
      emit_sym   = 9'd0;
      stk_we     = 1'b0;
      stk_waddr  = SA_W'(sp_ff);
      stk_wdata  = sym_rd_ff;
      cell_we    = 1'b0;
      cell_waddr = CA_W'(q_item.row) * CA_W'(NUM_TOKENS) + CA_W'(q_item.col);
      cell_wdata = q_item.entry_valid ? {1'b1, q_item.rule} : 9'd0;
      cell_raddr = CA_W'(row9) * CA_W'(NUM_TOKENS) + CA_W'(tok_ff);
      sym_we     = 1'b0;
      sym_waddr  = RSA_W'(q_item.rule) * RSA_W'(MAX_RULE_LEN) + RSA_W'(q_item.slot);
      sym_raddr  = RSA_W'(rule_ff) * RSA_W'(MAX_RULE_LEN) + RSA_W'(cnt_ff - 1'b1);
      len_we     = 1'b0;
      len_addr   = RA_W'(q_item.rule);

      unique case (state_ff)
         S_CLEAR: begin
            // sweep the parse table to invalid
            cell_we    = 1'b1;
            cell_waddr = clr_ff;
            cell_wdata = 9'd0;
            clr_in     = clr_ff + 1'b1;
            if (32'(clr_ff) == CELLS - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               tok_in = q_item.token_code;
               n_in   = '0;
               exp_in = '0;
               unique case (q_item.mode)
                  MODE_CELL: begin
                     cell_we = q_item.store_ok;
                  end
                  MODE_SYMBOL: begin
                     sym_we = q_item.store_ok;
                  end
                  MODE_LENGTH: begin
                     len_we = q_item.store_ok;
                  end
                  default: begin
                     if (!fin_ff) begin
                        if (!started_ff) begin
                           started_in = 1'b1;
                           if (q_item.token_code == cfg.eof_tok) begin
                              emit_go  = 1'b1;
                              sp_in    = '0;
                              fin_in   = 1'b1;
                              state_in = S_FINAL;
                           end else begin
                              stk_we    = 1'b1;
                              stk_waddr = '0;
                              stk_wdata = cfg.start_sym;
                              sp_in     = SP_W'(1);
                              state_in  = S_STEP;
                           end
                        end else if (skip_ff) begin
                           if (q_item.token_code == cfg.sync_tok) begin
                              skip_in  = 1'b0;
                              state_in = S_STEP;
                           end else if (q_item.token_code == cfg.eof_tok) begin
                              skip_in  = 1'b0;
                              emit_go  = 1'b1;
                              sp_in    = '0;
                              fin_in   = 1'b1;
                              state_in = S_FINAL;
                           end
                        end else begin
                           state_in = S_STEP;
                        end
                     end
                  end
               endcase
            end
         end
         S_STEP: begin
            if (can_emit) begin
               if (sp_ff == '0 || n_ff >= RESULT_LIMIT) begin
                  emit_go  = 1'b1;
                  sp_in    = '0;
                  fin_in   = 1'b1;
                  state_in = S_FINAL;
               end else if (top_ff < cfg.nt_base) begin
                  // terminal on top: match or mismatch, pop
                  emit_go   = 1'b1;
                  emit_kind = (top_ff == {1'b0, tok_ff}) ? EV_MATCH : EV_MISMATCH;
                  emit_sym  = top_ff;
                  sp_in     = sp_dec;
                  if (tok_ff != cfg.eof_tok) begin
                     state_in = (sp_dec == '0) ? S_FIN_EMIT : S_FINAL;
                  end
               end else begin
                  look_ok_in = (32'(row9) < NUM_NONTERMINALS) && (32'(tok_ff) < NUM_TOKENS);
                  state_in   = S_CELL;
               end
            end
         end
         S_CELL: begin
            if (can_emit) begin
               if (!look_ok_ff || !cell_rd_ff[8] || 32'(cell_rd_ff[7:0]) >= NUM_RULES) begin
                  emit_go   = 1'b1;
                  emit_kind = EV_NO_ENTRY;
                  emit_sym  = top_ff;
                  state_in  = S_SCAN;
               end else begin
                  rule_in  = RA_W'(cell_rd_ff[7:0]);
                  state_in = S_LEN;
               end
            end
         end
         S_SCAN: begin
            // pop through the sync terminal
            if (sp_ff != '0 && top_ff != {1'b0, cfg.sync_tok}) begin
               sp_in = sp_dec;
            end else begin
               if (sp_ff != '0) begin
                  sp_in = sp_dec;
               end
               if (tok_ff != cfg.eof_tok) begin
                  skip_in  = 1'b1;
                  state_in = S_FINAL;
               end else begin
                  if (tok_ff != cfg.sync_tok) begin
                     sp_in = '0;
                  end
                  state_in = S_STEP;
               end
            end
         end
         S_LEN: begin
            if (can_emit) begin
               exp_in = exp_ff + 1'b1;
               if (exp_ff >= EXPAND_LIMIT || need > (SP_W+1)'(STACK_DEPTH)) begin
                  emit_go   = 1'b1;
                  emit_kind = EV_OVERFLOW;
                  emit_sym  = top_ff;
                  sp_in     = '0;
                  fin_in    = 1'b1;
                  state_in  = S_FINAL;
               end else begin
                  sp_in    = sp_dec;
                  cnt_in   = len_rd_ff;
                  state_in = (len_rd_ff == 4'd0) ? S_STEP : S_EXP_RD;
               end
            end
         end
         S_EXP_RD: begin
            state_in = S_EXP_WR;
         end
         S_EXP_WR: begin
            // push rule symbols last to first
            stk_we   = 1'b1;
            sp_in    = sp_ff + 1'b1;
            cnt_in   = cnt_ff - 1'b1;
            state_in = (cnt_ff == 4'd1) ? S_STEP : S_EXP_RD;
         end
         S_FIN_EMIT: begin
            if (can_emit) begin
               emit_go  = 1'b1;
               sp_in    = '0;
               fin_in   = 1'b1;
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            if (!pend_valid_ff || out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit_go) begin
         n_in = n_ff + 1'b1;
      end
      stk_raddr = SA_W'(sp_in - 1'b1);
   end

   // hold one event back so the last one of a request can be marked
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_load      = 1'b0;
      out_in        = pend_ff;
      if (emit_go) begin
         if (pend_valid_ff) begin
            out_load    = 1'b1;
            out_in.last = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_in       = '{kind: emit_kind, symbol: emit_sym, token: tok_in, last: 1'b0};
      end else if (state_ff == S_FINAL && pend_valid_ff && out_free) begin
         out_load      = 1'b1;
         out_in.last   = 1'b1;
         pend_valid_in = 1'b0;
      end
      out_valid_in = out_load || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         sp_ff         <= '0;
         started_ff    <= 1'b0;
         skip_ff       <= 1'b0;
         fin_ff        <= 1'b0;
         clr_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sp_ff         <= sp_in;
         started_ff    <= started_in;
         skip_ff       <= skip_in;
         fin_ff        <= fin_in;
         clr_ff        <= clr_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      exp_ff     <= exp_in;
      tok_ff     <= tok_in;
      rule_ff    <= rule_in;
      cnt_ff     <= cnt_in;
      look_ok_ff <= look_ok_in;
      pend_ff    <= pend_in;
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   // symbol stack, top of stack read every cycle with write bypass
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_waddr] <= stk_wdata;
      end
      if (stk_we && stk_waddr == stk_raddr) begin
         top_ff <= stk_wdata;
      end else begin
         top_ff <= stack_mem[stk_raddr];
      end
   end

   // parse table
   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_waddr] <= cell_wdata;
      end
      cell_rd_ff <= cell_mem[cell_raddr];
   end

   // rule symbol store
   always_ff @(posedge clock) begin
      if (sym_we) begin
         sym_mem[sym_waddr] <= q_item.symbol;
      end
      sym_rd_ff <= sym_mem[sym_raddr];
   end

   // rule length store
   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[len_addr] <= q_item.length;
      end
      len_rd_ff <= len_mem[rule_in];
   end

endmodule

// ===== rtl/core/ll1_predictive_parse_engine.sv =====
// Table-driven LL(1) parse engine with panic-mode recovery. Requests with
// tuser 1, 2 and 3 load the parse table, rule symbols and rule lengths and
// give no response; tuser 0 requests are tokens, each parsed token answered
// by one or more events (match, mismatch, no entry, finished, overflow) with
// tlast on the last one, while ignored tokens and tokens dropped while
// skipping give none. After reset the engine sweeps all
// NUM_NONTERMINALS*NUM_TOKENS parse table entries (16384 by default) invalid
// with req_tready low. A request is taken by a two-entry front queue while
// the back end works. Loads, ignored tokens and tokens dropped while skipping
// are handled in the idle state alone. A parsed token is started, then takes
// each terminal, table lookup and pushed rule symbol in turn and is closed; a
// no-entry recovery pops stack entries through the sync terminal. A token's
// work is bounded by the stack and expansion limits. Each event needs a free
// slot in the response register.
module ll1_predictive_parse_engine import ll1p_pkg::*; #(
   parameter int STACK_DEPTH      = 64,
   parameter int MAX_RULE_LEN     = 8,
   parameter int NUM_RULES        = 256,
   parameter int NUM_NONTERMINALS = 64,
   parameter int NUM_TOKENS       = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // token_code, nonterminal_index, lookahead_code, rule_number,
   // entry_valid, symbol_slot, symbol_code, rule_length, zero pad
   input  logic [47:0] req_tdata,
   // mode
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // expected_symbol, found_token, zero pad
   output logic [23:0] rsp_tdata,
   // event_kind
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [8:0]  csr_wdata
);

   cfg_type    cfg_ff;
   item_type   q_item;
   logic       q_valid, q_pop;
   event_type  rsp_event;
   status_type stat;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.nt_base   <= RST_NT_BASE;
         cfg_ff.start_sym <= RST_START;
         cfg_ff.sync_tok  <= RST_SYNC;
         cfg_ff.eof_tok   <= RST_EOF;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_NT_BASE: cfg_ff.nt_base   <= csr_wdata;
            CSR_START:   cfg_ff.start_sym <= csr_wdata;
            CSR_SYNC:    cfg_ff.sync_tok  <= csr_wdata[7:0];
            default:     cfg_ff.eof_tok   <= csr_wdata[7:0];
         endcase
      end
   end

   ll1p_front #(
      .NUM_RULES        (NUM_RULES),
      .NUM_NONTERMINALS (NUM_NONTERMINALS),
      .NUM_TOKENS       (NUM_TOKENS),
      .MAX_RULE_LEN     (MAX_RULE_LEN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .clear_busy (stat.clear_busy),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   ll1p_back #(
      .STACK_DEPTH      (STACK_DEPTH),
      .MAX_RULE_LEN     (MAX_RULE_LEN),
      .NUM_RULES        (NUM_RULES),
      .NUM_NONTERMINALS (NUM_NONTERMINALS),
      .NUM_TOKENS       (NUM_TOKENS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_event (rsp_event),
      .stat      (stat)
   );

   assign rsp_tdata = {7'd0, rsp_event.token, rsp_event.symbol};
   assign rsp_tuser = rsp_event.kind;
   assign rsp_tlast = rsp_event.last;

   // no requests while the table sweep runs
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      stat.clear_busy |-> !req_tready)
      else $error("request ready during table clear");

   // finish and overflow always close a token's events
   a_finish_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == EV_FINISH || rsp_tuser == EV_OVERFLOW) |-> rsp_tlast)
      else $error("terminal event not marked last");

   // stack never grows past its depth
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      32'(stat.stack_count) <= STACK_DEPTH)
      else $error("stack count beyond depth");

   // once finished, the stack stays empty
   a_finished_empty: assert property (@(posedge clock) disable iff (reset)
      stat.finished && $past(stat.finished) |-> stat.stack_count == '0)
      else $error("stack not empty after finish");

endmodule

// ===== sim/ll1_parse_checker.sv =====
`timescale 1ns / 1ps

// Watches the request, response and register ports of the parse engine,
// keeps its own copy of the tables, stack and flags, and checks every event.
module ll1_parse_checker import ll1p_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [8:0]  csr_wdata,
   output int          errors,
   output int          pending
);

   localparam int DEPTH    = 64;
   localparam int RULE_LEN = 8;
   localparam int EV_LIMIT = 64;
   localparam int EXP_MAX  = 4096;

   logic [8:0] cells [16384];
   logic [8:0] rule_syms [2048];
   logic [3:0] rule_lens [256];
   logic [8:0] stk [DEPTH];
   int         sp;
   logic       started, skipping, done_flag;
   cfg_type    cfg;

   event_type  event_q [$];
   int         n_ev;

   assign pending = event_q.size();

   function automatic void add_event(logic [2:0] kind, logic [8:0] sym, logic [7:0] tok);
      event_type e;
      e.kind   = kind;
      e.symbol = sym;
      e.token  = tok;
      e.last   = 1'b0;
      event_q.push_back(e);
      n_ev++;
   endfunction

   function automatic void close_parse(logic [7:0] tok);
      sp = 0;
      add_event(EV_FINISH, 9'd0, tok);
      done_flag = 1'b1;
   endfunction

   // work out the events one token causes
   function automatic void parse_token(logic [7:0] tok);
      logic [8:0] top, cell_word;
      int         row, len, expansions;
      logic [7:0] rule;
      logic       run;
      expansions = 0;
      n_ev = 0;
      run = 1'b1;
      if (done_flag) return;
      if (!started) begin
         started = 1'b1;
         if (tok == cfg.eof_tok) begin
            close_parse(tok);
            run = 1'b0;
         end else begin
            stk[0] = cfg.start_sym;
            sp = 1;
         end
      end else if (skipping) begin
         if (tok == cfg.sync_tok) begin
            skipping = 1'b0;
         end else if (tok == cfg.eof_tok) begin
            skipping = 1'b0;
            close_parse(tok);
            run = 1'b0;
         end else begin
            return;
         end
      end
      while (run) begin
         if (sp == 0 || n_ev >= EV_LIMIT - 1) begin
            close_parse(tok);
            break;
         end
         top = stk[sp-1];
         // terminal on top: match or mismatch, pop
         if (top < cfg.nt_base) begin
            add_event((top == {1'b0, tok}) ? EV_MATCH : EV_MISMATCH, top, tok);
            sp--;
            if (tok != cfg.eof_tok) begin
               if (sp == 0) close_parse(tok);
               break;
            end
            continue;
         end
         row = int'(top) - int'(cfg.nt_base);
         cell_word = (row < 64) ? cells[{row[5:0], tok}] : 9'd0;
         // no entry: pop through the sync terminal, then skip tokens
         if (!cell_word[8]) begin
            add_event(EV_NO_ENTRY, top, tok);
            while (sp > 0 && stk[sp-1] != {1'b0, cfg.sync_tok}) sp--;
            if (sp > 0) sp--;
            if (tok != cfg.eof_tok) begin
               skipping = 1'b1;
               break;
            end
            if (tok != cfg.sync_tok) sp = 0;
            continue;
         end
         rule = cell_word[7:0];
         len = rule_lens[rule];
         if (len > RULE_LEN) len = RULE_LEN;
         expansions++;
         if (expansions > EXP_MAX || sp - 1 + len > DEPTH) begin
            add_event(EV_OVERFLOW, top, tok);
            sp = 0;
            done_flag = 1'b1;
            break;
         end
         sp--;
         for (int i = len; i > 0; i--) begin
            stk[sp] = rule_syms[{rule, 3'(i - 1)}];
            sp++;
         end
      end
      if (n_ev > 0) event_q[$].last = 1'b1;
   endfunction

   // track register writes and requests
   always @(posedge clock) begin
      if (reset) begin
         foreach (cells[i]) cells[i] = 9'd0;
         foreach (rule_syms[i]) rule_syms[i] = 9'd0;
         foreach (rule_lens[i]) rule_lens[i] = 4'd0;
         sp = 0;
         started = 1'b0;
         skipping = 1'b0;
         done_flag = 1'b0;
         cfg = '{RST_NT_BASE, RST_START, RST_SYNC, RST_EOF};
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_NT_BASE: cfg.nt_base = csr_wdata;
               CSR_START:   cfg.start_sym = csr_wdata;
               CSR_SYNC:    cfg.sync_tok = csr_wdata[7:0];
               CSR_EOF:     cfg.eof_tok = csr_wdata[7:0];
            endcase
         end
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               MODE_CELL:
                  cells[{req_tdata[13:8], req_tdata[21:14]}] =
                     req_tdata[30] ? {1'b1, req_tdata[29:22]} : 9'd0;
               MODE_SYMBOL: rule_syms[{req_tdata[29:22], req_tdata[33:31]}] = req_tdata[42:34];
               MODE_LENGTH:
                  rule_lens[req_tdata[29:22]] =
                     (req_tdata[46:43] > RULE_LEN) ? 4'(RULE_LEN) : req_tdata[46:43];
               default: parse_token(req_tdata[7:0]);
            endcase
         end
      end
   end

   // compare each event with the oldest expectation
   always @(posedge clock) begin
      event_type want;
      if (reset) begin
         errors <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (event_q.size() == 0) begin
            $error("unexpected event kind %0d symbol %0d token %0d",
                   rsp_tuser, rsp_tdata[8:0], rsp_tdata[16:9]);
            errors <= errors + 1;
         end else begin
            want = event_q.pop_front();
            if (rsp_tuser !== want.kind ||
                rsp_tdata[8:0] !== want.symbol ||
                rsp_tdata[16:9] !== want.token ||
                rsp_tlast !== want.last) begin
               if (rsp_tuser !== want.kind)
                  $error("event_kind expected %0d actual %0d", want.kind, rsp_tuser);
               if (rsp_tdata[8:0] !== want.symbol)
                  $error("expected_symbol expected %0d actual %0d", want.symbol, rsp_tdata[8:0]);
               if (rsp_tdata[16:9] !== want.token)
                  $error("found_token expected %0d actual %0d", want.token, rsp_tdata[16:9]);
               if (rsp_tlast !== want.last)
                  $error("last_event expected %0d actual %0d", want.last, rsp_tlast);
               errors <= errors + 1;
            end
         end
      end
   end

endmodule

// ===== sim/ll1_predictive_parse_engine_tb.sv =====
`timescale 1ns / 1ps

module ll1_predictive_parse_engine_tb;
   import ll1p_pkg::*;

   localparam int SEMI = 59;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [1:0]  req_tuser = MODE_TOKEN;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = CSR_NT_BASE;
   logic [8:0]  csr_wdata = '0;

   int   errors, pending;
   int   cycles = 0;
   int   nt_base = 448;
   int   eof_tok = 0;
   logic no_idle = 1'b0;
   logic hold_req = 1'b0;

   ll1_predictive_parse_engine DUT (.*);

   ll1_parse_checker checker_i (.*);

   always #5 clock = ~clock;

   // bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 600000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // drain responses with random stalls and one long hold-off
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         if (hold_req) begin
            rsp_tready = 1'b0;
            repeat (400) @(negedge clock);
            hold_req = 1'b0;
         end
         gap = no_idle ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   function automatic logic [47:0] pack_req(logic [7:0] tok, logic [5:0] row,
      logic [7:0] col, logic [7:0] rule, logic vld, logic [2:0] slot,
      logic [8:0] sym, logic [3:0] len);
      return {1'b0, len, sym, slot, vld, rule, col, row, tok};
   endfunction

   // offer one request, called and returning at a falling edge
   task automatic send_req(logic [1:0] mode, logic [47:0] data);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser = mode;
      req_tdata = data;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic send_tok(int t);
      send_req(MODE_TOKEN, pack_req(8'(t), 6'($urandom), 8'($urandom), 8'($urandom),
               1'($urandom), 3'($urandom), 9'($urandom), 4'($urandom)));
   endtask

   task automatic set_cell(int row, int col, int rule, bit vld);
      send_req(MODE_CELL, pack_req(8'($urandom), 6'(row), 8'(col), 8'(rule), vld,
               3'($urandom), 9'($urandom), 4'($urandom)));
   endtask

   task automatic set_sym(int rule, int slot, int sym);
      send_req(MODE_SYMBOL, pack_req(8'($urandom), 6'($urandom), 8'($urandom), 8'(rule),
               1'($urandom), 3'(slot), 9'(sym), 4'($urandom)));
   endtask

   task automatic set_len(int rule, int len);
      send_req(MODE_LENGTH, pack_req(8'($urandom), 6'($urandom), 8'($urandom), 8'(rule),
               1'($urandom), 3'($urandom), 9'($urandom), 4'(len)));
   endtask

   task automatic def_rule(int rule, int len, int s0, int s1, int s2);
      int syms [3];
      syms = '{s0, s1, s2};
      for (int i = 0; i < len; i++) set_sym(rule, i, syms[i]);
      set_len(rule, len);
   endtask

   task automatic csr_write(logic [1:0] addr, int value);
      csr_we = 1'b1;
      csr_addr = addr;
      csr_wdata = 9'(value);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // wait for every expected event, then let in-flight work settle
   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   // one statement, well formed most of the time
   task automatic send_stmt(inout int count);
      int pick, t;
      int odd_toks [3];
      odd_toks = '{7, 128, 200};
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1, 2: begin
            send_tok(10);
            repeat ($urandom_range(0, 3)) begin send_tok(13); count++; end
            send_tok(12);
            count += 2;
         end
         3, 4: begin send_tok(11); count++; end
         5, 6: begin repeat (3) send_tok(14); count += 3; end
         7: ;
         8: begin
            t = odd_toks[$urandom_range(0, 2)];
            send_tok(t);
            count++;
         end
         default: begin send_tok($urandom_range(10, 14)); count++; end
      endcase
      send_tok(SEMI);
      count++;
   endtask

   task automatic random_stmts(int n_tok);
      int count;
      count = 0;
      while (count < n_tok) send_stmt(count);
   endtask

   initial begin
      int s, a, e;
      int s_cols [9];
      s_cols = '{7, 10, 11, 12, 13, 14, 128, 200, 255};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // register extremes, then working values
      csr_write(CSR_NT_BASE, 1);
      csr_write(CSR_START, 511);
      csr_write(CSR_SYNC, 0);
      csr_write(CSR_EOF, 255);
      csr_write(CSR_NT_BASE, nt_base);
      csr_write(CSR_START, nt_base);
      csr_write(CSR_SYNC, SEMI);
      csr_write(CSR_EOF, eof_tok);
      s = nt_base;
      a = nt_base + 1;
      e = nt_base + 2;

      // field extremes on loads that the grammar never reads
      set_cell(63, 255, 255, 1'b1);
      set_cell(63, 255, 255, 1'b0);
      set_len(255, 15);
      set_sym(255, 7, 511);

      // statements: S -> A ; S | ; S | empty, A -> 10 E | 11 | 14 14 14,
      // E -> 12 | 13 E
      def_rule(0, 3, a, SEMI, s);
      def_rule(1, 0, 0, 0, 0);
      def_rule(2, 2, 10, e, 0);
      def_rule(3, 1, 11, 0, 0);
      def_rule(4, 1, 12, 0, 0);
      def_rule(5, 2, 13, e, 0);
      def_rule(6, 3, 14, 14, 14);
      def_rule(7, 2, SEMI, s, 0);
      set_cell(0, SEMI, 7, 1'b1);
      set_cell(0, 0, 1, 1'b1);
      foreach (s_cols[i]) set_cell(0, s_cols[i], 0, 1'b1);
      set_cell(1, 10, 2, 1'b1);
      set_cell(1, 11, 3, 1'b1);
      set_cell(1, 14, 6, 1'b1);
      set_cell(2, 12, 4, 1'b1);
      set_cell(2, 13, 5, 1'b1);

      // directed tokens: matches, recursion, mismatch, missing entries, skipping
      send_tok(11); send_tok(SEMI);
      send_tok(10); send_tok(13); send_tok(13); send_tok(12); send_tok(SEMI);
      send_tok(14); send_tok(11); send_tok(14); send_tok(SEMI);
      send_tok(10); send_tok(11); send_tok(7); send_tok(SEMI);
      send_tok(255); send_tok(128); send_tok(SEMI);
      send_tok(SEMI);
      send_tok(11); send_tok(12); send_tok(SEMI);
      drain();

      random_stmts(50);

      // long receiver hold-off while requests keep coming
      hold_req = 1'b1;
      no_idle = 1'b1;
      random_stmts(30);
      no_idle = 1'b0;
      drain();

      // new end-of-input code, unused loads with random content
      csr_write(CSR_EOF, 255);
      csr_write(CSR_START, 0);
      eof_tok = 255;
      set_cell(0, 255, 1, 1'b1);
      repeat (20) begin
         set_cell($urandom_range(10, 63), $urandom_range(0, 255), $urandom_range(8, 254),
                  1'($urandom));
         set_sym($urandom_range(100, 254), $urandom_range(0, 7), $urandom_range(0, 511));
         set_len($urandom_range(100, 254), $urandom_range(0, 15));
      end

      random_stmts(50);
      no_idle = 1'b1;
      random_stmts(35);
      no_idle = 1'b0;
      random_stmts(20);

      // end of input, then tokens the engine must ignore
      send_tok(eof_tok);
      send_tok(11);
      send_tok(SEMI);
      drain();

      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== ll1_predictive_parse_engine.f =====
rtl/core/ll1p_pkg.sv
rtl/core/ll1p_front.sv
rtl/core/ll1p_back.sv
rtl/core/ll1_predictive_parse_engine.sv
sim/ll1_parse_checker.sv
sim/ll1_predictive_parse_engine_tb.sv
